[sv/vlw_pkg.sv]
// shared constants, types and helpers of the voxel line walker
package vlw_pkg;

  localparam int unsigned MAX_DIM  = 64;
  localparam int unsigned IDX_W    = 18;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned COORD_W  = $clog2(MAX_DIM);
  localparam int unsigned XY_W     = 2 * COORD_W + 1;
  localparam int unsigned TOT_W    = 3 * COORD_W + 1;
  localparam int unsigned SHORT_W  = 2 * COORD_W;
  localparam int unsigned DCNT_W   = $clog2(IDX_W);
  localparam int unsigned ACC_W    = COORD_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SIZE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_XY,
    ST_MUL_ALL,
    ST_CHECK,
    ST_DIV_SX,
    ST_DIV_SY,
    ST_DIV_EX,
    ST_DIV_EY,
    ST_LOAD,
    ST_FIRST,
    ST_WALK
  } vlw_state_e;

  // setup handed to the line stepper
  typedef struct packed {
    logic [2:0][COORD_W-1:0] s_coord;
    logic [2:0][COORD_W-1:0] e_coord;
    logic [2:0][IDX_W-1:0]   stride;
    logic [IDX_W-1:0]        start;
  } walk_init_t;

  // what the stepper reports back
  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic             empty;
  } walk_stat_t;

  // zero acts as one, anything above the grid limit is clamped
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[sv/voxel_line_walker_3d_core.sv]
// voxel line walker top: config registers, sequencer, output register
// an item runs setup (two multiplies, a check that ends a single-voxel item),
// divider runs for the index splits (the end split is skipped for an out-of-grid
// end), stepper load, then one voxel per cycle (up to 64) while output is free
// one item at a time: tready is high only while the sequencer is idle
// reset: async active low, clears control state and sets all sizes to 64
module voxel_line_walker_3d_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,   // start_index, end_index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // voxel_index
  output logic                          m_axis_tlast,   // last_of_run
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vlw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vlw_pkg::SIZE_W-1:0]    cfg_data_i
);
  import vlw_pkg::*;

  vlw_state_e state_q, state_d;

  logic [SIZE_W-1:0] xs_cfg_q, ys_cfg_q, zs_cfg_q;
  logic [SIZE_W-1:0] xs, ys, zs;

  logic [IDX_W-1:0]        start_q, end_q;
  logic [XY_W-1:0]         xy_q;
  logic [TOT_W-1:0]        total_q;
  logic [2:0][COORD_W-1:0] sc_q, ec_q;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  logic             out_last_q;
  logic             out_free;

  logic               emit, emit_last;
  logic [IDX_W-1:0]   emit_index;
  logic               single, end_bad;

  logic               div_go, div_short, div_busy, div_done;
  logic [IDX_W-1:0]   div_dividend, div_quot;
  logic [SIZE_W-1:0]  div_divisor;
  logic [COORD_W-1:0] div_rem;

  logic       walk_load, walk_adv;
  walk_init_t walk_init;
  walk_stat_t walk_stat;

  assign xs = eff_size(xs_cfg_q);
  assign ys = eff_size(ys_cfg_q);
  assign zs = eff_size(zs_cfg_q);

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_cfg_q <= SIZE_RESET;
      ys_cfg_q <= SIZE_RESET;
      zs_cfg_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_X_SIZE: xs_cfg_q <= cfg_data_i;
        CFG_Y_SIZE: ys_cfg_q <= cfg_data_i;
        CFG_Z_SIZE: zs_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign single   = ({1'b0, start_q} >= total_q) || (start_q == end_q);
  assign end_bad  = {1'b0, end_q} >= total_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_MUL_XY;
      ST_MUL_XY:  state_d = ST_MUL_ALL;
      ST_MUL_ALL: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!single) begin
          state_d = ST_DIV_SX;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_SX:  if (div_done) state_d = ST_DIV_SY;
      ST_DIV_SY:  if (div_done) state_d = end_bad ? ST_LOAD : ST_DIV_EX;
      ST_DIV_EX:  if (div_done) state_d = ST_DIV_EY;
      ST_DIV_EY:  if (div_done) state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_FIRST;
      ST_FIRST:   if (out_free) state_d = walk_stat.empty ? ST_IDLE : ST_WALK;
      ST_WALK:    if (out_free && walk_stat.last) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_index    = start_q;
    div_go        = 1'b0;
    div_short     = 1'b0;
    div_dividend  = start_q;
    div_divisor   = xs;
    walk_load     = 1'b0;
    walk_adv      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CHECK: begin
        emit      = single && out_free;
        emit_last = 1'b1;
      end
      ST_DIV_SX: div_go = !div_busy && !div_done;
      ST_DIV_SY: begin
        div_go       = !div_busy && !div_done;
        div_short    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = ys;
      end
      ST_DIV_EX: begin
        div_go       = !div_busy && !div_done;
        div_dividend = end_q;
      end
      ST_DIV_EY: begin
        div_go       = !div_busy && !div_done;
        div_short    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = ys;
      end
      ST_LOAD: walk_load = 1'b1;
      ST_FIRST: begin
        emit      = out_free;
        emit_last = walk_stat.empty;
      end
      ST_WALK: begin
        emit       = out_free;
        walk_adv   = out_free;
        emit_index = walk_stat.index;
        emit_last  = walk_stat.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_index_q <= emit_index;
      out_last_q  <= emit_last;
    end
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      start_q <= s_axis_tdata[IDX_W-1:0];
      end_q   <= s_axis_tdata[2*IDX_W-1:IDX_W];
    end
    if (state_q == ST_MUL_XY) begin
      xy_q <= XY_W'(xs * ys);
    end
    if (state_q == ST_MUL_ALL) begin
      total_q <= TOT_W'(xy_q * zs);
    end
    if (state_q == ST_CHECK) begin
      // far corner for an end outside the grid
      ec_q[0] <= COORD_W'(xs - SIZE_W'(1));
      ec_q[1] <= COORD_W'(ys - SIZE_W'(1));
      ec_q[2] <= COORD_W'(zs - SIZE_W'(1));
    end
    if (div_done) begin
      case (state_q)
        ST_DIV_SX: sc_q[0] <= div_rem;
        ST_DIV_SY: begin
          sc_q[1] <= div_rem;
          sc_q[2] <= div_quot[COORD_W-1:0];
        end
        ST_DIV_EX: ec_q[0] <= div_rem;
        ST_DIV_EY: begin
          ec_q[1] <= div_rem;
          ec_q[2] <= div_quot[COORD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign walk_init.s_coord = sc_q;
  assign walk_init.e_coord = ec_q;
  assign walk_init.stride  = {IDX_W'(xy_q), IDX_W'(xs), IDX_W'(1)};
  assign walk_init.start   = start_q;

  vlw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .short_i    (div_short),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  vlw_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (walk_load),
    .init_i (walk_init),
    .adv_i  (walk_adv),
    .stat_o (walk_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(24-IDX_W){1'b0}}, out_index_q};
  assign m_axis_tlast  = out_last_q;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over an untaken result");
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider still running while idle");
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == ST_IDLE))
    else $error("sequencer kept going after the last voxel");

endmodule

[sv/vlw_div.sv]
// restoring divider, one quotient bit per cycle, shared by all index splits
module vlw_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic                        short_i,
  input  logic [vlw_pkg::IDX_W-1:0]   dividend_i,
  input  logic [vlw_pkg::SIZE_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [vlw_pkg::IDX_W-1:0]   quot_o,
  output logic [vlw_pkg::COORD_W-1:0] rem_o
);
  import vlw_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]    dvd_q, dvd_d;
  logic [SIZE_W-1:0]   dvs_q, dvs_d;
  logic [COORD_W-1:0]  rem_q, rem_d;
  logic [SIZE_W-1:0]   trial;
  logic                fits;
  logic [SIZE_W-1:0]   diff;

  assign trial = {rem_q, dvd_q[IDX_W-1]};
  assign fits  = trial >= dvs_q;
  assign diff  = trial - dvs_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (go_i) begin
      busy_d = 1'b1;
      dvs_d  = divisor_i;
      rem_d  = '0;
      // short form: dividend is narrow, left-align it and run fewer bits
      if (short_i) begin
        dvd_d = {dividend_i[SHORT_W-1:0], {(IDX_W-SHORT_W){1'b0}}};
        cnt_d = DCNT_W'(SHORT_W - 1);
      end else begin
        dvd_d = dividend_i;
        cnt_d = DCNT_W'(IDX_W - 1);
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      dvd_d = {dvd_q[IDX_W-2:0], fits};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

  a_go_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> !busy_q)
    else $error("divider started while busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (SIZE_W'(rem_q) < dvs_q))
    else $error("remainder not below divisor");

endmodule

[sv/vlw_walk.sv]
// line stepper: axis ordering at load, then one voxel per advance
module vlw_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  vlw_pkg::walk_init_t init_i,
  input  logic                adv_i,
  output vlw_pkg::walk_stat_t stat_o
);
  import vlw_pkg::*;

  logic [2:0][COORD_W-1:0] d_q, d_d;
  logic [2:0][IDX_W-1:0]   st_q, st_d;
  logic [ACC_W-1:0]        acc1_q, acc1_d, acc2_q, acc2_d;
  logic [IDX_W-1:0]        cur_q, cur_d;
  logic [COORD_W-1:0]      cnt_q, cnt_d;

  logic [2:0][COORD_W-1:0] sd;
  logic [2:0][IDX_W-1:0]   ss;
  logic [IDX_W-1:0]        nxt;
  logic                    ge1, ge2;
  logic [ACC_W:0]          a1, a2;

  // abs distance and signed stride per axis, then a stable descending sort
  always_comb begin
    logic [COORD_W-1:0] td;
    logic [IDX_W-1:0]   ts;
    td = '0;
    ts = '0;
    for (int i = 0; i < 3; i++) begin
      if (init_i.e_coord[i] < init_i.s_coord[i]) begin
        sd[i] = init_i.s_coord[i] - init_i.e_coord[i];
        ss[i] = '0 - init_i.stride[i];
      end else begin
        sd[i] = init_i.e_coord[i] - init_i.s_coord[i];
        ss[i] = init_i.stride[i];
      end
    end
    if (sd[0] < sd[1]) begin
      td = sd[0]; sd[0] = sd[1]; sd[1] = td;
      ts = ss[0]; ss[0] = ss[1]; ss[1] = ts;
    end
    if (sd[1] < sd[2]) begin
      td = sd[1]; sd[1] = sd[2]; sd[2] = td;
      ts = ss[1]; ss[1] = ss[2]; ss[2] = ts;
      if (sd[0] < sd[1]) begin
        td = sd[0]; sd[0] = sd[1]; sd[1] = td;
        ts = ss[0]; ss[0] = ss[1]; ss[1] = ts;
      end
    end
  end

  assign ge1 = acc1_q >= ACC_W'(d_q[0]);
  assign ge2 = acc2_q >= ACC_W'(d_q[0]);
  assign nxt = cur_q + st_q[0] + (ge1 ? st_q[1] : '0) + (ge2 ? st_q[2] : '0);
  assign a1  = (ACC_W+1)'(acc1_q) - (ge1 ? (ACC_W+1)'(d_q[0]) : '0)
             + (ACC_W+1)'(d_q[1]);
  assign a2  = (ACC_W+1)'(acc2_q) - (ge2 ? (ACC_W+1)'(d_q[0]) : '0)
             + (ACC_W+1)'(d_q[2]);

  always_comb begin
    d_d    = d_q;
    st_d   = st_q;
    acc1_d = acc1_q;
    acc2_d = acc2_q;
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      d_d    = sd;
      st_d   = ss;
      acc1_d = ACC_W'(sd[1]);
      acc2_d = ACC_W'(sd[2]);
      cur_d  = init_i.start;
      cnt_d  = '0;
    end else if (adv_i) begin
      acc1_d = a1[ACC_W-1:0];
      acc2_d = a2[ACC_W-1:0];
      cur_d  = nxt;
      cnt_d  = cnt_q + COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    st_q   <= st_d;
    acc1_q <= acc1_d;
    acc2_q <= acc2_d;
    cur_q  <= cur_d;
  end

  assign stat_o.index = nxt;
  assign stat_o.last  = (cnt_q == d_q[0] - COORD_W'(1));
  assign stat_o.empty = (d_q[0] == '0);

  a_adv_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |-> (d_q[0] != '0) && (cnt_q < d_q[0]))
    else $error("stepper advanced past the line end");
  a_load_adv_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !adv_i)
    else $error("stepper loaded and advanced together");
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (d_q[0] >= d_q[1]) && (d_q[1] >= d_q[2]))
    else $error("axis distances not in descending order");

endmodule
